[hdl/mip_pkg.sv]
// Shared types, constants and helpers for the icy-metaint header parser.
`timescale 1ns / 1ps

package mip_pkg;

  localparam logic [3:0] KEY_LEN = 4'd11;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [2:0] {
    PH_KEY    = 3'd0,
    PH_LEAD   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_BAD    = 3'd4,
    PH_SKIP   = 3'd5
  } mip_phase_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       block_end;
  } mip_byte_t;

  // Lowercase letters of "icy-metaint" by position.
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h69; // i
      4'd1:    ch = 8'h63; // c
      4'd2:    ch = 8'h79; // y
      4'd3:    ch = 8'h2D; // -
      4'd4:    ch = 8'h6D; // m
      4'd5:    ch = 8'h65; // e
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h61; // a
      4'd8:    ch = 8'h69; // i
      4'd9:    ch = 8'h6E; // n
      4'd10:   ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CASE_GAP) : c;
    return r;
  endfunction

endpackage

[hdl/mip_in_if.sv]
// Request channel carrying header bytes into the parser.
`timescale 1ns / 1ps

interface mip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       block_end;

  modport source (output valid, output header_byte, output block_end, input ready);
  modport sink   (input valid, input header_byte, input block_end, output ready);
endinterface

[hdl/mip_out_if.sv]
// Request channel carrying the parsed metadata interval.
`timescale 1ns / 1ps

interface mip_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] interval;

  modport source (output valid, output interval, input ready);
  modport sink   (input valid, input interval, output ready);
endinterface

[hdl/mip_in_stage.sv]
// Input register: holds one header byte until the parser takes it.
`timescale 1ns / 1ps

module mip_in_stage
  import mip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mip_in_if.sink    in_ch,
  input  logic      take,
  output logic      byte_valid,
  output mip_byte_t byte_data
);

  logic      valid_r, valid_nxt;
  mip_byte_t data_r, data_nxt;
  logic      load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt             = 1'b1;
      data_nxt.header_byte  = in_ch.header_byte;
      data_nxt.block_end    = in_ch.block_end;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

[hdl/mip_parser.sv]
// Parser state machine, decimal accumulator and result register.
`timescale 1ns / 1ps

module mip_parser
  import mip_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      byte_valid,
  input  mip_byte_t byte_data,
  output logic      take,
  mip_out_if.source out_ch
);

  localparam int PW = VALUE_BITS + 4;

  mip_phase_t            phase_r, phase_nxt, ph_a;
  logic [3:0]            key_pos_r, key_pos_nxt, kp_a;
  logic                  key_miss_r, key_miss_nxt, km_a;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt, acc_a;
  logic                  ovf_r, ovf_nxt, ovf_a;
  logic                  digit_r, digit_nxt, dig_a;
  logic                  answered_r, answered_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_interval_r, out_interval_nxt;

  logic [7:0]    c, lc;
  logic          last, line_end, is_blank, is_digit;
  logic [3:0]    dval;
  logic [PW-1:0] acc_ext, prod;
  logic          ended, key_res, good, emit;
  logic [31:0]   value;

  assign take = byte_valid && (!out_valid_r || out_ch.ready);

  assign c        = byte_data.header_byte;
  assign last     = byte_data.block_end;
  assign lc       = to_lower(c);
  assign line_end = (c == CH_CR) || (c == CH_LF);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dval     = 4'(c - CH_ZERO);

  // acc * 10 + digit; anything above VALUE_BITS is an overflow
  assign acc_ext = {4'b0000, acc_r};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_BITS{1'b0}}, dval};

  // Per-byte line scan
  always_comb begin
    ph_a  = phase_r;
    kp_a  = key_pos_r;
    km_a  = key_miss_r;
    acc_a = acc_r;
    ovf_a = ovf_r;
    dig_a = digit_r;
    if (!answered_r && !line_end) begin
      unique case (phase_r)
        PH_KEY: begin
          if (c == CH_COLON) begin
            ph_a = (!key_miss_r && key_pos_r == KEY_LEN) ? PH_LEAD : PH_SKIP;
          end else if (key_pos_r < KEY_LEN && lc == key_char(key_pos_r)) begin
            kp_a = key_pos_r + 4'd1;
          end else begin
            km_a = 1'b1;
          end
        end
        PH_LEAD, PH_DIGITS: begin
          if (is_digit) begin
            ph_a  = PH_DIGITS;
            dig_a = 1'b1;
            if (!ovf_r) begin
              if (prod[PW-1:VALUE_BITS] != 4'd0) begin
                ovf_a = 1'b1;
              end else begin
                acc_a = prod[VALUE_BITS-1:0];
              end
            end
          end else if (is_blank) begin
            if (phase_r == PH_DIGITS) begin
              ph_a = PH_TRAIL;
            end
          end else begin
            ph_a = PH_BAD;
          end
        end
        PH_TRAIL: begin
          if (!is_blank) begin
            ph_a = PH_BAD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result decision
  always_comb begin
    ended   = !answered_r && (line_end || last);
    key_res = ended && (ph_a == PH_LEAD || ph_a == PH_DIGITS ||
                        ph_a == PH_TRAIL || ph_a == PH_BAD);
    good    = (ph_a != PH_BAD) && dig_a && !ovf_a && (acc_a != '0);
    emit    = !answered_r && (key_res || last);
    value   = (key_res && good) ? 32'(acc_a) : 32'd0;
  end

  // Register updates
  always_comb begin
    phase_nxt        = phase_r;
    key_pos_nxt      = key_pos_r;
    key_miss_nxt     = key_miss_r;
    acc_nxt          = acc_r;
    ovf_nxt          = ovf_r;
    digit_nxt        = digit_r;
    answered_nxt     = answered_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_interval_nxt = out_interval_r;
    if (take) begin
      out_valid_nxt    = emit;
      out_interval_nxt = value;
      if (ended || last) begin
        phase_nxt    = PH_KEY;
        key_pos_nxt  = 4'd0;
        key_miss_nxt = 1'b0;
        acc_nxt      = '0;
        ovf_nxt      = 1'b0;
        digit_nxt    = 1'b0;
      end else begin
        phase_nxt    = ph_a;
        key_pos_nxt  = kp_a;
        key_miss_nxt = km_a;
        acc_nxt      = acc_a;
        ovf_nxt      = ovf_a;
        digit_nxt    = dig_a;
      end
      answered_nxt = last ? 1'b0 : (answered_r || key_res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEY;
      key_pos_r   <= 4'd0;
      key_miss_r  <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      digit_r     <= 1'b0;
      answered_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      key_pos_r   <= key_pos_nxt;
      key_miss_r  <= key_miss_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      digit_r     <= digit_nxt;
      answered_r  <= answered_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_interval_r <= out_interval_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.interval = out_interval_r;

  // Every block yields a result on its last byte unless one already went out
  a_block_answer: assert property (@(posedge clk) disable iff (!rst_n)
    take && last && !answered_r |=> out_valid_r)
    else $error("block ended without a result");

  // Nothing further once the key line has been answered
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    take && answered_r |=> !out_valid_r)
    else $error("second result in one block");

  // End of block returns the scanner to its idle state
  a_block_reset: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> phase_r == PH_KEY && !answered_r && key_pos_r == 4'd0)
    else $error("state not cleared at end of block");

  // Accumulator only moves once a value is being parsed
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_KEY |-> acc_r == '0 && !digit_r && !ovf_r)
    else $error("accumulator dirty while matching key");

endmodule

[hdl/metaint_header_parser_top.sv]
// Top level of the icy-metaint header parser.
// Usage:
//   in_ch  - request channel of header bytes (header_byte, block_end);
//            block_end marks the last byte of one header block.
//   out_ch - request channel of results (interval, 32 bits). Exactly one
//            result per block: the decimal value of the first icy-metaint
//            line, or 0 when absent, malformed, zero or above VALUE_BITS.
// Path: a byte accepted on in_ch sits in the input register and is parsed
//   from there into the result register.
// Throughput: one byte per clock while out_ch is not stalled, set by the
//   line scan between the input register and the result register.
// Reset: synchronous, active low; empties both registers and returns the
//   scanner to the start of a block.
// Stall: while out_ch is stalled the result is held; the input register
//   still takes one more byte, then in_ch.ready drops until the result
//   is taken.
// VALUE_BITS sets the accumulator width (8..64); the interval port carries
//   the low 32 bits of the value.
`timescale 1ns / 1ps

module metaint_header_parser_top
  import mip_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mip_in_if.sink    in_ch,
  mip_out_if.source out_ch
);

  logic      byte_valid;
  mip_byte_t byte_data;
  logic      take;

  // Input register: decouples the byte source from a stalled result
  mip_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Line scanner, value accumulator and result register
  mip_parser #(
    .VALUE_BITS (VALUE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

[tb/sv/metaint_header_parser_top_test.sv]
// Self-checking testbench: header blocks in, metadata intervals checked against a local parser.
`timescale 1ns / 1ps

module metaint_header_parser_top_test
  import mip_pkg::*;
();

  localparam int VALUE_BITS = 32;
  // Largest value that still fits the accumulator.
  localparam logic [63:0] VALUE_LIMIT = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [87:0] METAINT_KEY = "icy-metaint";
  localparam int CYCLE_LIMIT = 300000;
  // Requests left in the queue below which neither side idles any more.
  localparam int QUIET_TAIL = 250;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int RANDOM_BYTES = 1650;

  // One header byte as it goes over the input channel. hold_for_drain makes the
  // sender wait for every outstanding interval before it offers this byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold_for_drain;
  } hdr_request_t;

  logic clk = 1'b0;
  logic rst_n;

  mip_in_if  in_ch();
  mip_out_if out_ch();

  metaint_header_parser_top #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  hdr_request_t request_q[$];
  logic [31:0]  expected_interval_q[$];
  logic [7:0]   block_bytes[$];   // block under construction
  int           fail_count = 0;
  int           cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Line scanner mirror: tracks the same per-line state as the block and
  // pushes one expected interval per header block.
  // ---------------------------------------------------------------------------
  mip_phase_t  scan_phase;
  logic [3:0]  key_pos;
  logic        key_bad;
  logic [63:0] value_acc;
  logic        value_ovf;
  logic        digit_found;
  logic        block_answered;

  function automatic logic [7:0] key_letter(input int pos);
    return METAINT_KEY[8 * (10 - pos) +: 8];
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  task automatic clear_line();
    scan_phase  = PH_KEY;
    key_pos     = '0;
    key_bad     = 1'b0;
    value_acc   = '0;
    value_ovf   = 1'b0;
    digit_found = 1'b0;
  endtask

  // Once overflowed, further digits are swallowed but the value stays dead.
  task automatic accumulate_digit(input logic [7:0] ch);
    logic [63:0] d;
    d = 64'(ch - CH_ZERO);
    digit_found = 1'b1;
    if (!value_ovf) begin
      if (value_acc > (VALUE_LIMIT - d) / 64'd10) begin
        value_ovf = 1'b1;
      end else begin
        value_acc = value_acc * 64'd10 + d;
      end
    end
  endtask

  task automatic predict_interval(input logic [7:0] ch, input logic last);
    logic        line_end;
    logic [7:0]  lower;
    logic [63:0] v;
    line_end = (ch == CH_CR) || (ch == CH_LF);
    lower = ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) ? ch + CASE_GAP : ch;
    if (!block_answered) begin
      if (!line_end) begin
        case (scan_phase)
          PH_KEY: begin
            if (ch == CH_COLON) begin
              scan_phase = (!key_bad && key_pos == KEY_LEN) ? PH_LEAD : PH_SKIP;
            end else if (key_pos < KEY_LEN && lower == key_letter(int'(key_pos))) begin
              key_pos = key_pos + 4'd1;
            end else begin
              key_bad = 1'b1;
            end
          end
          PH_LEAD: begin
            if (is_digit(ch)) begin
              scan_phase = PH_DIGITS;
              accumulate_digit(ch);
            end else if (!is_blank(ch)) begin
              scan_phase = PH_BAD;
            end
          end
          PH_DIGITS: begin
            if (is_digit(ch)) begin
              accumulate_digit(ch);
            end else if (is_blank(ch)) begin
              scan_phase = PH_TRAIL;
            end else begin
              scan_phase = PH_BAD;
            end
          end
          PH_TRAIL: begin
            if (!is_blank(ch)) begin
              scan_phase = PH_BAD;
            end
          end
          default: ;
        endcase
      end
      // Key line closes on its line end or on the last byte of the block.
      if (line_end || last) begin
        if (scan_phase == PH_LEAD || scan_phase == PH_DIGITS ||
            scan_phase == PH_TRAIL || scan_phase == PH_BAD) begin
          v = '0;
          if (scan_phase != PH_BAD && digit_found && !value_ovf && value_acc != '0) begin
            v = value_acc;
          end
          expected_interval_q.push_back(v[31:0]);
          block_answered = 1'b1;
        end
        clear_line();
      end
      // No key line in the whole block: zero on the last byte.
      if (last && !block_answered) begin
        expected_interval_q.push_back('0);
      end
    end
    if (last) begin
      clear_line();
      block_answered = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Header block builders
  // ---------------------------------------------------------------------------
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      block_bytes.push_back(s[i]);
    end
  endtask

  task automatic put_eol();
    case ($urandom_range(0, 2))
      0: block_bytes.push_back(CH_CR);
      1: block_bytes.push_back(CH_LF);
      default: begin
        block_bytes.push_back(CH_CR);
        block_bytes.push_back(CH_LF);
      end
    endcase
  endtask

  task automatic put_blanks();
    repeat ($urandom_range(0, 2)) begin
      block_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    end
  endtask

  // Key with random letter case; mutate_at < 0 leaves every letter intact.
  task automatic put_key(input int mutate_at, input int key_len);
    logic [7:0] ch;
    for (int i = 0; i < key_len; i++) begin
      ch = key_letter(i);
      if (i == mutate_at) begin
        ch = $urandom_range(0, 1) ? 8'h78 : (8'h80 | ch);
      end else if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(0, 1)) begin
        ch = ch - CASE_GAP;
      end
      block_bytes.push_back(ch);
    end
  endtask

  // Value text after the colon: mostly clean numbers, some near and past the
  // 32-bit edge, zeros, empty values and values with junk inside or after.
  task automatic put_value();
    logic [63:0] v;
    string       digits;
    int          cut;
    case ($urandom_range(0, 9))
      0, 1, 2: v = 64'($urandom_range(1, 99999));
      3:       v = {32'd0, $urandom};
      4:       v = 64'hFFFF_FFFF;
      5:       v = 64'h1_0000_0000 + 64'($urandom_range(0, 3));
      6:       v = {$urandom, $urandom};
      7:       v = '0;
      8:       v = 64'($urandom_range(1, 9));
      default: v = 64'd4294967290 + 64'($urandom_range(0, 9));
    endcase
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 3) == 0) begin
      digits = {"00", digits};
    end
    put_blanks();
    case ($urandom_range(0, 9))
      0: ;  // no digits at all
      1: begin
        cut = $urandom_range(0, digits.len() - 1);
        put_text(digits.substr(0, cut - 1));
        block_bytes.push_back(8'($urandom_range(0, 255)));
        put_text(digits.substr(cut, digits.len() - 1));
      end
      2: begin
        put_text(digits);
        put_blanks();
        put_text("x");
      end
      default: begin
        put_text(digits);
        put_blanks();
      end
    endcase
  endtask

  // A header line that is not the key line (or a key line after the answer).
  task automatic put_other_line();
    case ($urandom_range(0, 7))
      0: put_text("content-type: audio/mpeg");
      1: put_text("icy-name:Test");
      2: put_text("icy-br: 128");
      3: put_text("no colon here");
      4: begin
        case ($urandom_range(0, 4))
          0: put_key($urandom_range(0, 10), 11);
          1: put_key(-1, $urandom_range(1, 10));
          2: begin
            put_key(-1, 11);
            put_text("s");
          end
          3: begin
            put_key(-1, 11);
            put_text(" ");
          end
          default: put_key(-1, 0);
        endcase
        put_text(":");
        put_value();
      end
      5: put_key(-1, 11);  // key text without a colon
      6: repeat ($urandom_range(1, 6)) block_bytes.push_back(8'($urandom_range(0, 255)));
      default: begin
        put_key(-1, 11);
        put_text(":");
        put_value();
      end
    endcase
  endtask

  task automatic commit_block(input logic drain);
    hdr_request_t r;
    if (block_bytes.size() == 0) begin
      block_bytes.push_back(CH_LF);
    end
    foreach (block_bytes[i]) begin
      r.data           = block_bytes[i];
      r.last           = (i == block_bytes.size() - 1);
      r.hold_for_drain = drain && (i == 0);
      request_q.push_back(r);
    end
    block_bytes.delete();
  endtask

  // Typical response header: a few other lines, usually one key line, and
  // sometimes more lines (even another key line) after it.
  task automatic build_random_block(input logic drain);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) != 0) begin
        put_other_line();
      end
      put_eol();
    end
    if ($urandom_range(0, 6) != 0) begin
      put_key(-1, 11);
      put_text(":");
      put_value();
      if ($urandom_range(0, 3) != 0) begin
        put_eol();
        repeat ($urandom_range(0, 2)) begin
          put_other_line();
          put_eol();
        end
      end
    end
    commit_block(drain);
  endtask

  task automatic build_directed_blocks();
    put_text("icy-metaint:8192");
    block_bytes.push_back(CH_CR);
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    put_text("ICY-MetaInt: \t16000 \t");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    // value closed by the last byte of the block
    put_text("icy-metaint:4294967295");
    commit_block(1'b0);
    put_text("icy-metaint:4294967296");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    // zero value; CR is also the last byte
    put_text("iCy-mEtAiNt:0");
    block_bytes.push_back(CH_CR);
    commit_block(1'b0);
    put_text("icy-metaint:12a");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    put_text("icy-metaint: \t");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    // empty lines and other headers skipped, second key line ignored
    put_text("content-type:x");
    block_bytes.push_back(CH_CR);
    block_bytes.push_back(CH_LF);
    block_bytes.push_back(CH_CR);
    block_bytes.push_back(CH_LF);
    put_text("nocolon");
    block_bytes.push_back(CH_LF);
    put_text("icy-metaint:1");
    block_bytes.push_back(CH_LF);
    put_text("icy-metaint:2");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    // near misses only: zero at the last byte
    put_text("icy-metaintx:5");
    block_bytes.push_back(CH_LF);
    put_text("icy-meta:5");
    block_bytes.push_back(CH_LF);
    put_text("icy-metaint");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    put_text("icy-metaint:7 x");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    // high bytes and NUL never match a key letter
    block_bytes.push_back(8'hFF);
    block_bytes.push_back(8'h00);
    block_bytes.push_back(CH_LF);
    put_text("icy-meta");
    block_bytes.push_back(8'hC9);
    put_text("nt:5");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    put_text("icy-metaint:00042");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    put_text("icy-metaint:9");
    commit_block(1'b0);
    // colon inside the key text; doubled colon makes the value bad
    put_text("x:icy-metaint:3");
    block_bytes.push_back(CH_LF);
    put_text("icy-metaint::3");
    block_bytes.push_back(CH_LF);
    commit_block(1'b0);
    // bytes after the answer, last byte gives nothing
    put_text("icy-metaint:5");
    block_bytes.push_back(CH_LF);
    block_bytes.push_back(CH_LF);
    put_text("trailing stuff");
    commit_block(1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers the head of request_q, with random gaps between requests.
  // The predictor runs on the byte taken at this edge.
  // ---------------------------------------------------------------------------
  int           send_gap = 0;
  logic         send_offer;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_interval(in_ch.header_byte, in_ch.block_end);
        void'(request_q.pop_front());
      end
      // A request still waiting for ready stays put.
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          send_offer = 1'b0;
        end else if (request_q.size() == 0) begin
          send_offer = 1'b0;
        end else if (request_q[0].hold_for_drain && expected_interval_q.size() != 0) begin
          send_offer = 1'b0;
        end else begin
          send_offer = 1'b1;
        end
        in_ch.valid <= send_offer;
        if (send_offer) begin
          in_ch.header_byte <= request_q[0].data;
          in_ch.block_end   <= request_q[0].last;
          if (request_q.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
            send_gap = $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each interval against the oldest expectation; stalls in
  // bursts, and once for a long stretch so the block backs up into in_ch.
  // ---------------------------------------------------------------------------
  logic [31:0] want_interval;
  int          results_taken = 0;
  int          recv_stall = 0;
  int          long_hold = 0;
  logic        long_hold_done = 1'b0;
  logic        recv_ready;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_interval_q.size() == 0) begin
          $error("interval: expected none, got %0d", out_ch.interval);
          fail_count++;
        end else begin
          want_interval = expected_interval_q.pop_front();
          if (out_ch.interval !== want_interval) begin
            $error("interval: expected %0d, got %0d", want_interval, out_ch.interval);
            fail_count++;
          end
        end
        results_taken++;
      end
      if (!long_hold_done && results_taken >= 20) begin
        long_hold      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (long_hold > 0) begin
        long_hold--;
        recv_ready = 1'b0;
      end else if (request_q.size() <= QUIET_TAIL) begin
        recv_ready = 1'b1;
      end else if (recv_stall > 0) begin
        recv_stall--;
        recv_ready = 1'b0;
      end else begin
        recv_ready = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          recv_stall = $urandom_range(1, 10);
        end
      end
      out_ch.ready <= recv_ready;
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  int random_blocks;

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.header_byte = '0;
    in_ch.block_end   = 1'b0;
    out_ch.ready      = 1'b0;
    clear_line();
    block_answered = 1'b0;

    build_directed_blocks();
    // First random block waits for the directed results to drain.
    random_blocks = 0;
    while (request_q.size() < RANDOM_BYTES || random_blocks < 48) begin
      build_random_block(random_blocks == 0 || $urandom_range(0, 11) == 0);
      random_blocks++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_ch.valid || expected_interval_q.size() != 0) begin
      @(posedge clk);
    end
    // Result path is two registers deep; leave room for a stray result.
    repeat (4) @(posedge clk);

    if (fail_count == 0 && expected_interval_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
